// File: hw/rtl/tkh_pkg.sv
package tkh_pkg;

  // heap depth
  localparam int CAPACITY = 16;
  // width of a heap position (1..CAPACITY) or entry count (0..CAPACITY)
  localparam int PW = $clog2(CAPACITY + 1);
  // memory address width
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // width of a child position (up to 2*CAPACITY+1)
  localparam int CW = PW + 1;

  localparam int KEEP_W = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
  localparam int RANK_W = 4;

  typedef enum logic {
    REQ_OFFER = 1'b0,
    REQ_DRAIN = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] score;
    logic [30:0]        item_index;
  } tkh_in_t;

  typedef struct packed {
    logic [30:0]        out_index;
    logic signed [15:0] out_score;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } tkh_out_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic [30:0]        index;
  } tkh_entry_t;

  // one write port, two read ports
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    tkh_entry_t    wdata;
    logic          re;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
  } tkh_mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DR_RD,
    ST_DR_POP
  } tkh_state_t;

endpackage

// File: hw/rtl/tkh_heap_ram.sv
module tkh_heap_ram (
  input  logic                 clk,
  input  tkh_pkg::tkh_mem_req_t req,
  output tkh_pkg::tkh_entry_t  rd0,
  output tkh_pkg::tkh_entry_t  rd1
);

  tkh_pkg::tkh_entry_t mem_r [tkh_pkg::CAPACITY];
  tkh_pkg::tkh_entry_t rd0_r;
  tkh_pkg::tkh_entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd0_r <= mem_r[req.raddr0];
      rd1_r <= mem_r[req.raddr1];
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

// File: hw/rtl/tkh_ctrl.sv
module tkh_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tkh_pkg::KEEP_W-1:0]   keep_count,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tkh_pkg::tkh_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tkh_pkg::tkh_out_t            out_data,
  output tkh_pkg::tkh_mem_req_t        mem_req,
  input  tkh_pkg::tkh_entry_t          rd0,
  input  tkh_pkg::tkh_entry_t          rd1
);

  tkh_pkg::tkh_state_t state_r, state_nxt;
  logic [tkh_pkg::PW-1:0] count_r, count_nxt;
  logic [tkh_pkg::PW-1:0] pos_r, pos_nxt;
  tkh_pkg::tkh_entry_t    x_r, x_nxt;
  logic                   draining_r, draining_nxt;
  logic                   out_valid_r, out_valid_nxt;
  tkh_pkg::tkh_out_t      out_data_r, out_data_nxt;

  logic [tkh_pkg::PW-1:0] k_eff;
  logic [tkh_pkg::CW-1:0] lchild, rchild;
  logic [tkh_pkg::PW-1:0] parent;
  logic                   l_ok, r_ok;
  tkh_pkg::tkh_entry_t    best_val;
  logic [tkh_pkg::CW-1:0] best_pos;
  tkh_pkg::tkh_state_t    done_st;

  always_comb begin
    if (keep_count == '0) begin
      k_eff = tkh_pkg::PW'(1);
    end else if (int'(keep_count) > tkh_pkg::CAPACITY) begin
      k_eff = tkh_pkg::PW'(tkh_pkg::CAPACITY);
    end else begin
      k_eff = tkh_pkg::PW'(keep_count);
    end
  end

  assign lchild = {pos_r, 1'b0};
  assign rchild = {pos_r, 1'b1};
  assign parent = pos_r >> 1;
  assign l_ok   = lchild <= {1'b0, count_r};
  assign r_ok   = rchild <= {1'b0, count_r};
  assign done_st = draining_r ? tkh_pkg::ST_DR_RD : tkh_pkg::ST_IDLE;

  // smallest of hole entry and children; the hole entry wins ties, then the left child
  always_comb begin
    best_val = x_r;
    best_pos = {1'b0, pos_r};
    if (l_ok && ($signed(rd0.score) < $signed(best_val.score))) begin
      best_val = rd0;
      best_pos = lchild;
    end
    if (r_ok && ($signed(rd1.score) < $signed(best_val.score))) begin
      best_val = rd1;
      best_pos = rchild;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkh_pkg::ST_IDLE;
      count_r     <= '0;
      draining_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      draining_r  <= draining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    x_nxt         = x_r;
    draining_nxt  = draining_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_req       = '0;

    case (state_r)
      tkh_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_nxt.score = in_data.score;
          x_nxt.index = in_data.item_index;
          if (in_data.req_type == tkh_pkg::REQ_DRAIN) begin
            draining_nxt = 1'b1;
            state_nxt    = tkh_pkg::ST_DR_RD;
          end else if (count_r >= k_eff) begin
            draining_nxt = 1'b0;
            state_nxt    = tkh_pkg::ST_ROOT_RD;
          end else begin
            draining_nxt = 1'b0;
            count_nxt    = count_r + tkh_pkg::PW'(1);
            pos_nxt      = count_r + tkh_pkg::PW'(1);
            state_nxt    = tkh_pkg::ST_UP_RD;
          end
        end
      end

      tkh_pkg::ST_ROOT_RD: begin
        mem_req.re     = 1'b1;
        mem_req.raddr0 = '0;
        state_nxt      = tkh_pkg::ST_ROOT_CMP;
      end

      tkh_pkg::ST_ROOT_CMP: begin
        if ($signed(x_r.score) > $signed(rd0.score)) begin
          pos_nxt   = tkh_pkg::PW'(1);
          state_nxt = tkh_pkg::ST_DN_RD;
        end else begin
          state_nxt = tkh_pkg::ST_IDLE;
        end
      end

      tkh_pkg::ST_UP_RD: begin
        if (pos_r == tkh_pkg::PW'(1)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = x_r;
          state_nxt     = tkh_pkg::ST_IDLE;
        end else begin
          mem_req.re     = 1'b1;
          mem_req.raddr0 = tkh_pkg::AW'(parent - tkh_pkg::PW'(1));
          state_nxt      = tkh_pkg::ST_UP_CMP;
        end
      end

      tkh_pkg::ST_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = tkh_pkg::AW'(pos_r - tkh_pkg::PW'(1));
        if ($signed(x_r.score) < $signed(rd0.score)) begin
          // parent moves down into the hole
          mem_req.wdata = rd0;
          pos_nxt       = parent;
          state_nxt     = tkh_pkg::ST_UP_RD;
        end else begin
          mem_req.wdata = x_r;
          state_nxt     = tkh_pkg::ST_IDLE;
        end
      end

      tkh_pkg::ST_DN_RD: begin
        if (!l_ok) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = tkh_pkg::AW'(pos_r - tkh_pkg::PW'(1));
          mem_req.wdata = x_r;
          state_nxt     = done_st;
        end else begin
          // right child address may run past the heap; r_ok masks it
          mem_req.re     = 1'b1;
          mem_req.raddr0 = tkh_pkg::AW'(lchild - tkh_pkg::CW'(1));
          mem_req.raddr1 = tkh_pkg::AW'(lchild);
          state_nxt      = tkh_pkg::ST_DN_CMP;
        end
      end

      tkh_pkg::ST_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = tkh_pkg::AW'(pos_r - tkh_pkg::PW'(1));
        mem_req.wdata = best_val;
        if (best_pos == {1'b0, pos_r}) begin
          state_nxt = done_st;
        end else begin
          pos_nxt   = tkh_pkg::PW'(best_pos);
          state_nxt = tkh_pkg::ST_DN_RD;
        end
      end

      tkh_pkg::ST_DR_RD: begin
        if (count_r == '0) begin
          draining_nxt = 1'b0;
          state_nxt    = tkh_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          mem_req.re     = 1'b1;
          mem_req.raddr0 = '0;
          mem_req.raddr1 = tkh_pkg::AW'(count_r - tkh_pkg::PW'(1));
          state_nxt      = tkh_pkg::ST_DR_POP;
        end
      end

      tkh_pkg::ST_DR_POP: begin
        // output slot was freed when the reads were issued
        out_valid_nxt          = 1'b1;
        out_data_nxt.out_index = rd0.index;
        out_data_nxt.out_score = rd0.score;
        out_data_nxt.rank      = tkh_pkg::RANK_W'(count_r - tkh_pkg::PW'(1));
        out_data_nxt.last      = (count_r == tkh_pkg::PW'(1));
        x_nxt                  = rd1;
        count_nxt              = count_r - tkh_pkg::PW'(1);
        if (count_r == tkh_pkg::PW'(1)) begin
          draining_nxt = 1'b0;
          state_nxt    = tkh_pkg::ST_IDLE;
        end else begin
          pos_nxt   = tkh_pkg::PW'(1);
          state_nxt = tkh_pkg::ST_DN_RD;
        end
      end

      default: begin
        state_nxt = tkh_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != tkh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/top_k_min_heap_select_top.sv
// Top-k selector: keeps the keep_count highest-scoring entries in a min-heap
// held in one 1W2R synchronous RAM (root = weakest entry kept).
//
// Input channel (in_valid/in_stall/in_data): one request per handshake.
//   Offer request: appended and sifted up while the heap holds fewer than k
//   entries; otherwise replaces the root only if its score is strictly
//   greater, then sifts down. No result.
//   Drain request: pops every entry held in ascending score order, one result
//   each, tagged with its descending rank; last marks rank 0. Heap ends empty.
// Output channel (out_valid/out_stall/out_data): registered output slot.
// Config: cfg_wr_en/cfg_wr_data write keep_count (0 acts as 1, values above
//   the capacity act as the capacity). Write only while the block is idle.
// Timing: each heap level is handled as a RAM read state followed by a compare
// and write-back state. An offer into a full heap first reads and compares the
// root; each drain pop reads the root and the last entry, then sifts the moved
// last entry down.
// One request is in flight at a time; in_stall is high while it is worked.
// A stalled result holds the output slot; the next pop waits for it to clear.
// Reset (rst_n low, synchronous): heap empty, keep_count = 16, no result.
module top_k_min_heap_select_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tkh_pkg::tkh_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tkh_pkg::tkh_out_t           out_data,
  input  logic                        cfg_wr_en,
  input  logic [tkh_pkg::KEEP_W-1:0]  cfg_wr_data
);

  logic [tkh_pkg::KEEP_W-1:0] keep_r;
  tkh_pkg::tkh_mem_req_t      mem_req;
  tkh_pkg::tkh_entry_t        rd0;
  tkh_pkg::tkh_entry_t        rd1;

  // keep_count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= tkh_pkg::KEEP_RESET;
    end else if (cfg_wr_en) begin
      keep_r <= cfg_wr_data;
    end
  end

  // sequencer: sift up / sift down / drain
  tkh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .keep_count (keep_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mem_req    (mem_req),
    .rd0        (rd0),
    .rd1        (rd1)
  );

  // heap storage, slot n of the heap at address n-1
  tkh_heap_ram u_ram (
    .clk (clk),
    .req (mem_req),
    .rd0 (rd0),
    .rd1 (rd1)
  );

endmodule

// File: hw/rtl/tkh_checker.sv
module tkh_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input tkh_pkg::tkh_in_t            in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input tkh_pkg::tkh_out_t           out_data
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("not idle after reset");

  // every accepted request raises in_stall, so the block goes busy
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without busy cycle");

  // an offer never produces a result
  a_offer_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.req_type == tkh_pkg::REQ_OFFER) && !out_valid)
      |=> !out_valid)
    else $error("result after offer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind top_k_min_heap_select_top tkh_checker u_tkh_checker (.*);
